FILE: rtl/rvix_pkg.sv
// ----------------------------------------------------------------------------
// rvix_pkg
// shared constants, codes and types of the value array with reverse index
// ----------------------------------------------------------------------------
package rvix_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int VALUE_RANGE  = 1024;

    localparam int POS_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = POS_W + 1;
    localparam int VAL_W = $clog2(VALUE_RANGE);

    // packed stream widths
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        K_APPEND  = 2'd0,
        K_REPLACE = 2'd1,
        K_READ    = 2'd2,
        K_CLEAR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_LOOK2,
        S_UNMAP,
        S_SWEEP,
        S_DONE
    } t_state;

endpackage

FILE: rtl/rvix_ram.sv
// ----------------------------------------------------------------------------
// rvix_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rvix_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/value_replace_with_reverse_index_unit.sv
// ----------------------------------------------------------------------------
// value_replace_with_reverse_index_unit
// array of distinct values with a reverse map from value to position
// ----------------------------------------------------------------------------
// The unit holds up to 256 distinct 10-bit values in an element ram and keeps
// a 1024-entry position map ram (position + 1, zero meaning absent). One
// transaction at a time is worked on and gives exactly one result. Append and
// read pass through one lookup state before the done state, which loads the
// output register once it is free. A replace that goes through steps through
// a map lookup of the old value, a map lookup of the new value, a write of the
// new map entry and array entry, then clearing of the old map entry; a refused
// replace stops after the second lookup. All of this is paced by the single
// read and single write port of the map ram. Clear walks the whole map ram
// writing one entry a cycle. After reset the same walk runs before the first
// input transaction is taken; it gives no result. A finished result sits in
// the output register while the next transaction is accepted. A failed
// append or replace changes nothing and is flagged in status.
// ----------------------------------------------------------------------------
module value_replace_with_reverse_index_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input transactions
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // position [7:0], value [17:8], new_value [27:18], zero [31:28]
    input  logic [rvix_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind [1:0]
    input  logic [rvix_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // result transactions
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_value [9:0], found_position [17:10], zero [23:18]
    output logic [rvix_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output logic [rvix_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    import rvix_pkg::*;

    // input field split
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    logic [VAL_W-1:0] in_nval;
    t_kind            in_kind;

    assign in_pos  = s_axis_tdata[POS_W-1:0];
    assign in_val  = s_axis_tdata[POS_W +: VAL_W];
    assign in_nval = s_axis_tdata[POS_W+VAL_W +: VAL_W];
    assign in_kind = t_kind'(s_axis_tuser);

    // control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [VAL_W-1:0] r_sweep, n_sweep;
    logic             r_clr_reply, n_clr_reply;
    logic             r_out_valid, n_out_valid;

    // captured transaction and working result
    t_kind            r_kind, n_kind;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [VAL_W-1:0] r_val, n_val;
    logic [VAL_W-1:0] r_nval, n_nval;
    logic [CNT_W-1:0] r_oldp, n_oldp;
    t_status          r_res_status, n_res_status;
    logic [VAL_W-1:0] r_res_rd, n_res_rd;
    logic [POS_W-1:0] r_res_found, n_res_found;

    // output register
    t_status          r_out_status, n_out_status;
    logic [VAL_W-1:0] r_out_rd, n_out_rd;
    logic [POS_W-1:0] r_out_found, n_out_found;

    // memory ports
    logic             map_we;
    logic [VAL_W-1:0] map_waddr;
    logic [CNT_W-1:0] map_wdata;
    logic [VAL_W-1:0] map_raddr;
    logic [CNT_W-1:0] map_rdata;
    logic             elem_we;
    logic [POS_W-1:0] elem_waddr;
    logic [VAL_W-1:0] elem_wdata;
    logic [POS_W-1:0] elem_raddr;
    logic [VAL_W-1:0] elem_rdata;

    logic             in_fire;
    logic             out_free;
    logic             store_full;
    logic [CNT_W-1:0] old_pos;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !r_out_valid || m_axis_tready;
    assign store_full = (r_count == CNT_W'(MAX_ELEMENTS));
    assign old_pos    = r_oldp - CNT_W'(1);

    // value -> position + 1
    rvix_ram #(
        .WIDTH (CNT_W),
        .DEPTH (VALUE_RANGE)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // position -> value, entries at or above the fill count are never used
    rvix_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (in_kind == K_CLEAR) ? S_SWEEP : S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = (r_kind == K_REPLACE) ? S_LOOK2 : S_DONE;
            end
            S_LOOK2: begin
                // a replace only goes on when the old value is there and the new one is not
                if (r_oldp != '0 && map_rdata == '0) begin
                    n_state = S_UNMAP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UNMAP: begin
                n_state = S_DONE;
            end
            S_SWEEP: begin
                if (r_sweep == VAL_W'(VALUE_RANGE - 1)) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath, memory control and handshake
    always_comb begin
        n_count      = r_count;
        n_sweep      = r_sweep;
        n_clr_reply  = r_clr_reply;
        n_kind       = r_kind;
        n_pos        = r_pos;
        n_val        = r_val;
        n_nval       = r_nval;
        n_oldp       = r_oldp;
        n_res_status = r_res_status;
        n_res_rd     = r_res_rd;
        n_res_found  = r_res_found;
        n_out_status = r_out_status;
        n_out_rd     = r_out_rd;
        n_out_found  = r_out_found;
        n_out_valid  = r_out_valid && !m_axis_tready;

        map_we     = 1'b0;
        map_waddr  = r_val;
        map_wdata  = '0;
        map_raddr  = in_val;
        elem_we    = 1'b0;
        elem_waddr = r_count[POS_W-1:0];
        elem_wdata = r_val;
        elem_raddr = in_pos;

        s_axis_tready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_kind       = in_kind;
                    n_pos        = in_pos;
                    n_val        = in_val;
                    n_nval       = in_nval;
                    n_res_status = ST_OK;
                    n_res_rd     = '0;
                    n_res_found  = '0;
                    if (in_kind == K_CLEAR) begin
                        n_count     = '0;
                        n_sweep     = '0;
                        n_clr_reply = 1'b1;
                    end
                end
            end
            S_LOOK: begin
                case (r_kind)
                    K_APPEND: begin
                        if (map_rdata != '0) begin
                            n_res_status = ST_PRESENT;
                        end else if (store_full) begin
                            n_res_status = ST_INVALID;
                        end else begin
                            elem_we     = 1'b1;
                            map_we      = 1'b1;
                            map_wdata   = r_count + CNT_W'(1);
                            n_res_found = r_count[POS_W-1:0];
                            n_count     = r_count + CNT_W'(1);
                        end
                    end
                    K_REPLACE: begin
                        // old entry arrives, look up the new value next
                        n_oldp    = map_rdata;
                        map_raddr = r_nval;
                    end
                    K_READ: begin
                        if ({1'b0, r_pos} < r_count) begin
                            n_res_rd = elem_rdata;
                        end else begin
                            n_res_status = ST_INVALID;
                        end
                    end
                    default: begin
                        n_res_status = ST_OK;
                    end
                endcase
            end
            S_LOOK2: begin
                if (r_oldp == '0) begin
                    n_res_status = ST_ABSENT;
                end else if (map_rdata != '0) begin
                    // covers new equal to old
                    n_res_status = ST_PRESENT;
                end else begin
                    elem_we     = 1'b1;
                    elem_waddr  = old_pos[POS_W-1:0];
                    elem_wdata  = r_nval;
                    map_we      = 1'b1;
                    map_waddr   = r_nval;
                    map_wdata   = r_oldp;
                    n_res_found = old_pos[POS_W-1:0];
                end
            end
            S_UNMAP: begin
                map_we    = 1'b1;
                map_waddr = r_val;
                map_wdata = '0;
            end
            S_SWEEP: begin
                map_we    = 1'b1;
                map_waddr = r_sweep;
                map_wdata = '0;
                n_sweep   = r_sweep + VAL_W'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_rd     = r_res_rd;
                    n_out_found  = r_res_found;
                    n_clr_reply  = 1'b0;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    // control registers, reset starts the map walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_count     <= '0;
            r_sweep     <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sweep     <= n_sweep;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_nval       <= n_nval;
        r_oldp       <= n_oldp;
        r_res_status <= n_res_status;
        r_res_rd     <= n_res_rd;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_rd     <= n_out_rd;
        r_out_found  <= n_out_found;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - VAL_W - POS_W)'(0), r_out_found, r_out_rd};
    assign m_axis_tuser  = OUT_USER_W'(r_out_status);

    // an accepted transaction always leaves idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state != S_IDLE)
        else $error("accepted transaction did not start work");

    // the map walk writes zero to every entry it passes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP |-> map_we && map_wdata == '0 && map_waddr == r_sweep)
        else $error("map walk did not clear its entry");

    // a successful append grows the fill count by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && r_kind == K_APPEND && map_rdata == '0 && !store_full)
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("append did not advance fill count");

    // the fill count never passes the array depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> r_count <= CNT_W'(MAX_ELEMENTS))
        else $error("fill count beyond array depth");

endmodule

FILE: tb/value_replace_with_reverse_index_unit_tb.sv
// ----------------------------------------------------------------------------
// value_replace_with_reverse_index_unit_tb
// self-checking bench for the value array with reverse index
// ----------------------------------------------------------------------------
// A short table of directed transactions comes first. It covers reads of an
// empty store, duplicate appends, replaces of absent values and replaces onto
// present values, a replace with the new value equal to the old one, and
// clears. Then random traffic runs: mostly well-formed sequences built from
// the values that are present now, one pass that fills the store and goes on
// appending once it is full, and a few clears. A shadow copy of the array,
// the reverse map and the count predicts every unpinned result. Both stream sides
// idle at random, and the sender drains the unit completely at least once.
// ----------------------------------------------------------------------------
module value_replace_with_reverse_index_unit_tb;

    import rvix_pkg::*;

    localparam int QUIET_LIMIT  = 8000;    // outlasts a clear walk over the whole map
    localparam int IDLE_PCT     = 17;
    localparam int DIRECTED_CNT = 23;
    localparam int TOTAL_ITEMS  = 450;

    // one input transaction
    typedef struct {
        t_kind             kind;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        logic [VAL_W-1:0]  nval;
    } t_op;

    // one result transaction
    typedef struct {
        t_status           status;
        logic [VAL_W-1:0]  read_value;
        logic [POS_W-1:0]  found_pos;
    } t_result;

    // directed row: pinned rows carry a result read straight off the spec
    typedef struct {
        t_op      op;
        bit       pinned;
        t_result  res;
    } t_stim_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;   // position, value, new_value, zero pad
    logic [IN_USER_W-1:0]    s_axis_tuser;   // kind
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;   // read_value, found_position, zero pad
    logic [OUT_USER_W-1:0]   m_axis_tuser;   // status

    // shadow state of the unit
    logic [VAL_W-1:0]  shadow_vals [MAX_ELEMENTS];
    logic [CNT_W-1:0]  shadow_map  [VALUE_RANGE];   // position + 1, zero when absent
    logic [CNT_W-1:0]  shadow_count;

    t_result    pending_results [$];
    t_stim_row  directed_rows [DIRECTED_CNT];

    // expectation override for the transaction on the bus right now
    bit         pin_expect;
    t_result    pinned_result;

    bit         calm;            // no idling on either side while set
    int         mismatch_count;
    int         sent_items;
    int         result_idx;
    int         quiet_cycles;

    value_replace_with_reverse_index_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor: applies one transaction to the shadow state
    // ------------------------------------------------------------------
    function automatic t_result predict_result(t_op op);
        t_result           res;
        logic [CNT_W-1:0]  slot;
        res.status     = ST_OK;
        res.read_value = '0;
        res.found_pos  = '0;
        case (op.kind)
            K_APPEND: begin
                if (shadow_map[op.val] != 0) begin
                    res.status = ST_PRESENT;
                end else if (shadow_count >= CNT_W'(MAX_ELEMENTS)) begin
                    res.status = ST_INVALID;
                end else begin
                    shadow_vals[shadow_count[POS_W-1:0]] = op.val;
                    shadow_map[op.val] = shadow_count + 1'b1;
                    res.found_pos = shadow_count[POS_W-1:0];
                    shadow_count = shadow_count + 1'b1;
                end
            end
            K_REPLACE: begin
                // old value is checked before the new one
                if (shadow_map[op.val] == 0) begin
                    res.status = ST_ABSENT;
                end else if (shadow_map[op.nval] != 0) begin
                    res.status = ST_PRESENT;
                end else begin
                    slot = shadow_map[op.val] - 1'b1;
                    shadow_vals[slot[POS_W-1:0]] = op.nval;
                    shadow_map[op.nval] = slot + 1'b1;
                    shadow_map[op.val]  = '0;
                    res.found_pos = slot[POS_W-1:0];
                end
            end
            K_READ: begin
                if (CNT_W'(op.pos) < shadow_count) begin
                    res.read_value = shadow_vals[op.pos];
                end else begin
                    res.status = ST_INVALID;
                end
            end
            default: begin
                for (int v = 0; v < VALUE_RANGE; v++) shadow_map[v] = '0;
                shadow_count = '0;
            end
        endcase
        return res;
    endfunction

    function automatic t_stim_row stim_row(t_kind k, int p, int v, int nv, bit pin,
                                           t_status st, int rd, int fp);
        t_stim_row r;
        r.op.kind        = k;
        r.op.pos         = POS_W'(p);
        r.op.val         = VAL_W'(v);
        r.op.nval        = VAL_W'(nv);
        r.pinned         = pin;
        r.res.status     = st;
        r.res.read_value = VAL_W'(rd);
        r.res.found_pos  = POS_W'(fp);
        return r;
    endfunction

    // any value present in the store now
    function automatic logic [VAL_W-1:0] present_value();
        return shadow_vals[$urandom_range(int'(shadow_count) - 1)];
    endfunction

    // a value that is absent now; the store never holds every value, so one exists
    function automatic logic [VAL_W-1:0] absent_value();
        logic [VAL_W-1:0] v;
        do v = VAL_W'($urandom_range(VALUE_RANGE - 1)); while (shadow_map[v] != 0);
        return v;
    endfunction

    // random transaction, biased toward values that are present
    function automatic t_op pick_op(int clear_pct);
        t_op op;
        int  r;
        int  s;
        op.pos  = POS_W'($urandom_range(255));
        op.val  = VAL_W'($urandom_range(VALUE_RANGE - 1));
        op.nval = VAL_W'($urandom_range(VALUE_RANGE - 1));
        r = $urandom_range(99);
        if (r < clear_pct) begin
            op.kind = K_CLEAR;
        end else if (r < 40) begin
            op.kind = K_APPEND;
            if (shadow_count != 0 && $urandom_range(99) < 25) op.val = present_value();
        end else if (r < 72) begin
            op.kind = K_REPLACE;
            if (shadow_count != 0 && $urandom_range(99) < 85) op.val = present_value();
            s = $urandom_range(99);
            if (s < 10) begin
                op.nval = op.val;
            end else if (s < 25 && shadow_count != 0) begin
                op.nval = present_value();
            end
        end else begin
            op.kind = K_READ;
            if (shadow_count != 0 && $urandom_range(99) < 85) begin
                op.pos = POS_W'($urandom_range(int'(shadow_count) - 1));
            end
        end
        return op;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // sender: called at a falling edge, returns at the falling edge after
    // the transaction was taken
    // ------------------------------------------------------------------
    task automatic send_op(t_op op, bit pin, t_result want);
        int gap;
        gap = (!calm && $urandom_range(99) < IDLE_PCT) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'd0, op.nval, op.val, op.pos};
        s_axis_tuser  = op.kind;
        pin_expect    = pin;
        pinned_result = want;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_random(t_op op);
        t_result none;
        none.status     = ST_OK;
        none.read_value = '0;
        none.found_pos  = '0;
        send_op(op, 1'b0, none);
    endtask

    // hold off the sender until every expected result is back
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver side: ready idles at random except in calm stretches
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_axis_tready = calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // scoreboard: results are checked first, then the accepted input
    // transaction is predicted, so the queue order is fixed within a step
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result pred;
        t_op     op;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            moved          = 1'b1;
            got.status     = t_status'(m_axis_tuser);
            got.read_value = m_axis_tdata[VAL_W-1:0];
            got.found_pos  = m_axis_tdata[VAL_W+POS_W-1:VAL_W];
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          result_idx));
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              result_idx, got.status, want.status));
                if (got.read_value != want.read_value)
                    report_mismatch($sformatf("result %0d read_value %0d, expected %0d",
                                              result_idx, got.read_value, want.read_value));
                if (got.found_pos != want.found_pos)
                    report_mismatch($sformatf("result %0d found_position %0d, expected %0d",
                                              result_idx, got.found_pos, want.found_pos));
            end
            result_idx++;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            moved   = 1'b1;
            op.kind = t_kind'(s_axis_tuser);
            op.pos  = s_axis_tdata[POS_W-1:0];
            op.val  = s_axis_tdata[POS_W+VAL_W-1:POS_W];
            op.nval = s_axis_tdata[POS_W+2*VAL_W-1:POS_W+VAL_W];
            pred    = predict_result(op);
            pending_results.push_back(pin_expect ? pinned_result : pred);
        end
        // watchdog on cycles where no transaction moves on either side
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** value_replace_with_reverse_index_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_op op;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = K_APPEND;
        pin_expect     = 1'b0;
        pinned_result  = '{ST_OK, '0, '0};
        calm           = 1'b0;
        mismatch_count = 0;
        sent_items     = 0;
        result_idx     = 0;
        quiet_cycles   = 0;
        shadow_count   = '0;
        for (int v = 0; v < VALUE_RANGE; v++) shadow_map[v] = '0;
        for (int p = 0; p < MAX_ELEMENTS; p++) shadow_vals[p] = '0;

        // kind, position, value, new_value, pinned, status, read_value, found
        directed_rows = '{
            stim_row(K_READ,      0,    0,    0, 1, ST_INVALID, 0,    0), // empty store
            stim_row(K_REPLACE,   0,    5,    6, 1, ST_ABSENT,  0,    0), // nothing to replace
            stim_row(K_APPEND,    0,    0,    0, 1, ST_OK,      0,    0),
            stim_row(K_APPEND,    0, 1023,    0, 1, ST_OK,      0,    1),
            stim_row(K_APPEND,    0,    0,    0, 1, ST_PRESENT, 0,    0), // duplicate append
            stim_row(K_READ,      0,    0,    0, 1, ST_OK,      0,    0),
            stim_row(K_READ,      1,    0,    0, 1, ST_OK,      1023, 0),
            stim_row(K_READ,      2,    0,    0, 1, ST_INVALID, 0,    0), // just past the end
            stim_row(K_READ,    255,    0,    0, 1, ST_INVALID, 0,    0),
            stim_row(K_REPLACE,   0, 1023, 1023, 1, ST_PRESENT, 0,    0), // new equals old
            stim_row(K_REPLACE,   0,    0, 1023, 1, ST_PRESENT, 0,    0), // new already present
            stim_row(K_REPLACE,   0, 1023,  682, 0, ST_OK,      0,    0),
            stim_row(K_READ,      1,    0,    0, 0, ST_OK,      0,    0),
            stim_row(K_REPLACE,   0, 1023,    5, 1, ST_ABSENT,  0,    0), // old one was moved
            stim_row(K_APPEND,    0, 1023,    0, 0, ST_OK,      0,    0), // freed value reused
            stim_row(K_REPLACE,   0,    0,  341, 0, ST_OK,      0,    0),
            stim_row(K_APPEND,    0,    0,    0, 0, ST_OK,      0,    0),
            stim_row(K_REPLACE,   0,  999,    0, 1, ST_ABSENT,  0,    0), // absent wins over present
            stim_row(K_APPEND,  255,  341, 1023, 1, ST_PRESENT, 0,    0), // unused fields ignored
            stim_row(K_CLEAR,   255, 1023, 1023, 1, ST_OK,      0,    0),
            stim_row(K_READ,      0,    0,    0, 1, ST_INVALID, 0,    0), // nothing left
            stim_row(K_APPEND,    0,  682,    0, 1, ST_OK,      0,    0), // map cleared too
            stim_row(K_CLEAR,     0,    0,    0, 1, ST_OK,      0,    0)
        };

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table; the unit's power-up map walk is waited out by ready
        foreach (directed_rows[i]) begin
            send_op(directed_rows[i].op, directed_rows[i].pinned, directed_rows[i].res);
        end
        drain_results();

        // mixed traffic on a small store
        repeat (140) send_random(pick_op(3));
        drain_results();

        // fill the store to the limit, first part without any idling
        op = pick_op(0);
        op.kind = K_CLEAR;
        send_random(op);
        while (shadow_count < CNT_W'(MAX_ELEMENTS)) begin
            calm = (shadow_count < CNT_W'(120));
            op = pick_op(0);
            op.kind = K_APPEND;
            op.val  = absent_value();
            send_random(op);
        end
        calm = 1'b0;

        // full store: appends are refused, reads and replaces still work
        op = pick_op(0);
        op.kind = K_APPEND;
        op.val  = absent_value();
        send_random(op);
        op.val = present_value();
        send_random(op);
        op.kind = K_READ;
        op.pos  = POS_W'(MAX_ELEMENTS - 1);
        send_random(op);
        op.kind = K_REPLACE;
        op.val  = present_value();
        op.nval = absent_value();
        send_random(op);
        op.kind = K_READ;
        send_random(op);
        op.kind = K_CLEAR;
        send_random(op);

        // more mixed traffic until the item budget is spent
        while (sent_items < TOTAL_ITEMS) send_random(pick_op(2));

        drain_results();
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0) begin
            $display("** value_replace_with_reverse_index_unit: PASSED **");
        end else begin
            $display("** value_replace_with_reverse_index_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: value_replace_with_reverse_index_unit.f
rtl/rvix_pkg.sv
rtl/rvix_ram.sv
rtl/value_replace_with_reverse_index_unit.sv
tb/value_replace_with_reverse_index_unit_tb.sv
